@@ src/assert_macros.svh @@
// assertion macros shared by the transcoder rtl
// no dependencies; included by modules that check their own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

@@ src/u2u8_pkg.sv @@
// types and constants for the utf-16 to utf-8 transcoder
// no dependencies; imported by every module of the block
package u2u8_pkg;

  localparam logic [15:0] SURR_HIGH_FIRST = 16'hD800;
  localparam logic [15:0] SURR_HIGH_LAST  = 16'hDBFF;
  localparam logic [15:0] SURR_LOW_FIRST  = 16'hDC00;
  localparam logic [15:0] SURR_LOW_LAST   = 16'hDFFF;
  localparam logic [15:0] ONE_BYTE_LIMIT  = 16'h0080;
  localparam logic [15:0] TWO_BYTE_LIMIT  = 16'h0800;
  localparam logic [20:0] SUPP_BASE       = 21'h10000;
  localparam logic [7:0]  LEAD2           = 8'hC0;
  localparam logic [7:0]  LEAD3           = 8'hE0;
  localparam logic [7:0]  LEAD4           = 8'hF0;
  localparam logic [7:0]  CONT            = 8'h80;

  // one classified item: up to four bytes, first byte in slot 0
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
    logic            has_byte;
    logic            string_end;
  } u2u8_entry_t;

  // queue status seen by the front and the back
  typedef struct packed {
    logic full;
    logic empty;
  } u2u8_qstat_t;

endpackage

@@ src/u2u8_front.sv @@
// front part: accepts code units, tracks surrogate/termination state, builds entries
// depends on u2u8_pkg and assert_macros.svh
`include "assert_macros.svh"
module u2u8_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [15:0]           code_unit_i,
  input  logic                  last_unit_i,
  input  u2u8_pkg::u2u8_qstat_t qstat_i,
  output logic                  push_o,
  output u2u8_pkg::u2u8_entry_t entry_o
);
  import u2u8_pkg::*;

  logic [9:0]  held_q, held_d;
  logic        held_valid_q, held_valid_d;
  logic        term_q, term_d;
  logic [20:0] cp;
  logic        is_low;
  logic        accept;

  assign in_ready_o = !qstat_i.full;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = accept;

  assign is_low = (code_unit_i >= SURR_LOW_FIRST) && (code_unit_i <= SURR_LOW_LAST);
  assign cp     = SUPP_BASE + {1'b0, held_q, 10'b0} + {11'b0, code_unit_i[9:0]};

  always_comb begin
    entry_o            = '0;
    entry_o.string_end = last_unit_i;
    held_d             = held_q;
    held_valid_d       = held_valid_q;
    term_d             = term_q;
    if (term_q) begin
      term_d = 1'b1;
    end else if (code_unit_i == '0) begin
      held_d       = '0;
      held_valid_d = 1'b0;
      term_d       = 1'b1;
    end else if (held_valid_q && is_low) begin
      held_d           = '0;
      held_valid_d     = 1'b0;
      entry_o.has_byte = 1'b1;
      entry_o.last_idx = 2'd3;
      entry_o.bytes[0] = LEAD4 | {5'b0, cp[20:18]};
      entry_o.bytes[1] = CONT | {2'b0, cp[17:12]};
      entry_o.bytes[2] = CONT | {2'b0, cp[11:6]};
      entry_o.bytes[3] = CONT | {2'b0, cp[5:0]};
    end else begin
      // a held high surrogate not followed by a low one is dropped
      held_d       = '0;
      held_valid_d = 1'b0;
      if (code_unit_i < ONE_BYTE_LIMIT) begin
        entry_o.has_byte = 1'b1;
        entry_o.last_idx = 2'd0;
        entry_o.bytes[0] = code_unit_i[7:0];
      end else if (code_unit_i < TWO_BYTE_LIMIT) begin
        entry_o.has_byte = 1'b1;
        entry_o.last_idx = 2'd1;
        entry_o.bytes[0] = LEAD2 | {3'b0, code_unit_i[10:6]};
        entry_o.bytes[1] = CONT | {2'b0, code_unit_i[5:0]};
      end else if ((code_unit_i >= SURR_HIGH_FIRST) && (code_unit_i <= SURR_HIGH_LAST)) begin
        held_d       = code_unit_i[9:0];
        held_valid_d = 1'b1;
      end else begin
        entry_o.has_byte = 1'b1;
        entry_o.last_idx = 2'd2;
        entry_o.bytes[0] = LEAD3 | {4'b0, code_unit_i[15:12]};
        entry_o.bytes[1] = CONT | {2'b0, code_unit_i[11:6]};
        entry_o.bytes[2] = CONT | {2'b0, code_unit_i[5:0]};
      end
    end
    // end of string always leaves a clean state
    if (last_unit_i) begin
      held_d       = '0;
      held_valid_d = 1'b0;
      term_d       = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q       <= '0;
      held_valid_q <= 1'b0;
      term_q       <= 1'b0;
    end else if (accept) begin
      held_q       <= held_d;
      held_valid_q <= held_valid_d;
      term_q       <= term_d;
    end
  end

  `ASSERT_NEXT(a_last_clears_state, clk_i, rst_ni, accept && last_unit_i,
               !held_valid_q && !term_q)
  `ASSERT_IMPL(a_held_not_term, clk_i, rst_ni, held_valid_q, !term_q)

endmodule

@@ src/u2u8_queue.sv @@
// small fifo of classified entries between front and back
// depends on u2u8_pkg and assert_macros.svh
`include "assert_macros.svh"
module u2u8_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  u2u8_pkg::u2u8_entry_t push_data_i,
  input  logic                  pop_i,
  output u2u8_pkg::u2u8_entry_t head_o,
  output u2u8_pkg::u2u8_qstat_t qstat_o
);
  import u2u8_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  u2u8_entry_t     slots_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign head_o        = slots_q[rd_ptr_q];
  assign qstat_o.full  = (count_q == CntFull);
  assign qstat_o.empty = (count_q == '0);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  `ASSERT_IMPL(a_no_push_full, clk_i, rst_ni, push_i, !qstat_o.full)
  `ASSERT_IMPL(a_no_pop_empty, clk_i, rst_ni, pop_i, !qstat_o.empty)

endmodule

@@ src/u2u8_back.sv @@
// back part: walks the head entry one byte per cycle into the output register,
// unless the output stalls; depends on u2u8_pkg and assert_macros.svh
`include "assert_macros.svh"
module u2u8_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  u2u8_pkg::u2u8_entry_t head_i,
  input  u2u8_pkg::u2u8_qstat_t qstat_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [7:0]            utf8_byte_o,
  output logic                  has_byte_o,
  output logic                  run_last_o,
  output logic                  string_end_o
);
  import u2u8_pkg::*;

  logic [1:0] idx_q, idx_d;
  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       has_q, run_last_q, end_q;
  logic       load;
  logic       at_last;

  assign load    = !qstat_i.empty && (!valid_q || out_ready_i);
  assign at_last = (idx_q == head_i.last_idx);
  assign pop_o   = load && at_last;

  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    if (load) begin
      idx_d   = at_last ? 2'd0 : idx_q + 2'd1;
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q     <= head_i.bytes[idx_q];
      has_q      <= head_i.has_byte;
      run_last_q <= at_last;
      end_q      <= at_last && head_i.string_end;
    end
  end

  assign out_valid_o  = valid_q;
  assign utf8_byte_o  = byte_q;
  assign has_byte_o   = has_q;
  assign run_last_o   = run_last_q;
  assign string_end_o = end_q;

  `ASSERT_IMPL(a_end_on_run_last, clk_i, rst_ni, valid_q && end_q, run_last_q)
  `ASSERT_IMPL(a_empty_is_single, clk_i, rst_ni, valid_q && !has_q, run_last_q)

endmodule

@@ src/utf16_to_utf8_converter.sv @@
// top level of the utf-16 to utf-8 transcoder
// depends on u2u8_pkg, u2u8_front, u2u8_queue and u2u8_back
//
// usage:
//   input channel: one utf-16 code unit per item (code_unit_i, last_unit_i),
//     taken when in_valid_i and in_ready_o are both high
//   output channel: one result per item (utf8_byte_o, has_byte_o, run_last_o,
//     string_end_o), taken when out_valid_o and out_ready_i are both high
//   each code unit gives one to four results; units that give no byte (held
//     high surrogate, zero terminator, units after the terminator) give one
//     result with has_byte_o low; run_last_o marks the last result of a unit,
//     string_end_o the last result of the unit flagged last_unit_i
//   path: a taken unit is written into the queue; its results are loaded from
//     the queue head into the output register, one result per cycle while
//     out_ready_i is high; the front classifies a unit per cycle while the
//     queue is not full and runs ahead by up to QUEUE_DEPTH entries
//   reset: the queue empties, the output goes invalid, any held surrogate and
//     the terminated flag are cleared
//   stall: while out_ready_i is low the output register holds, the queue fills,
//     and in_ready_o falls once the queue is full
`include "assert_macros.svh"
module utf16_to_utf8_converter #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] code_unit_i,
  input  logic        last_unit_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  utf8_byte_o,
  output logic        has_byte_o,
  output logic        run_last_o,
  output logic        string_end_o
);
  import u2u8_pkg::*;

  u2u8_entry_t push_entry;
  u2u8_entry_t head_entry;
  u2u8_qstat_t qstat;
  logic        push;
  logic        pop;

  // front: classification and surrogate state
  u2u8_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .code_unit_i (code_unit_i),
    .last_unit_i (last_unit_i),
    .qstat_i     (qstat),
    .push_o      (push),
    .entry_o     (push_entry)
  );

  // queue decouples the one-unit-per-cycle front from the byte-per-cycle back
  u2u8_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_entry),
    .pop_i       (pop),
    .head_o      (head_entry),
    .qstat_o     (qstat)
  );

  // back: serializes bytes into the output register
  u2u8_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head_entry),
    .qstat_i      (qstat),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .utf8_byte_o  (utf8_byte_o),
    .has_byte_o   (has_byte_o),
    .run_last_o   (run_last_o),
    .string_end_o (string_end_o)
  );

  // an output stall with a full queue must hold off the input
  `ASSERT_IMPL(a_stall_backpressure, clk_i, rst_ni, qstat.full, !in_ready_o)

endmodule

@@ tb/sv/utf8_stream_checker.sv @@
`timescale 1ns / 1ps
// stream checker for the utf-16 to utf-8 transcoder: predicts bytes per code unit
// and compares each output item in order; depends on u2u8_pkg only
module utf8_stream_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [15:0] code_unit_i,
  input  logic        last_unit_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [7:0]  utf8_byte_i,
  input  logic        has_byte_i,
  input  logic        run_last_i,
  input  logic        string_end_i,
  output int          error_count_o,
  output int          expected_left_o,
  output int          units_seen_o,
  output int          results_seen_o,
  output int          strings_seen_o
);
  import u2u8_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       run_last;
    logic       string_end;
  } utf8_result_t;

  utf8_result_t expected_bytes_q[$];

  // predictor state
  logic [9:0] held_bits;
  logic       held_valid;
  logic       string_done;

  int errors;
  int units;
  int results;
  int strings;

  // expected utf-8 items for one accepted code unit
  task automatic encode_utf8_unit(input logic [15:0] cu, input logic last);
    logic [7:0]   seq [4];
    int           n;
    logic         paired;
    logic [20:0]  cp;
    utf8_result_t r;
    n = 0;
    paired = 1'b0;
    if (!string_done) begin
      if (cu == 16'h0000) begin
        held_valid  = 1'b0;
        held_bits   = '0;
        string_done = !last;
      end else begin
        if (held_valid) begin
          held_valid = 1'b0;
          if (cu >= SURR_LOW_FIRST && cu <= SURR_LOW_LAST) begin
            cp = SUPP_BASE + {1'b0, held_bits, 10'b0} + {5'b0, cu - SURR_LOW_FIRST};
            seq[0] = LEAD4 | {5'b0, cp[20:18]};
            seq[1] = CONT | {2'b0, cp[17:12]};
            seq[2] = CONT | {2'b0, cp[11:6]};
            seq[3] = CONT | {2'b0, cp[5:0]};
            n = 4;
            paired = 1'b1;
          end
          held_bits = '0;
        end
        if (!paired) begin
          if (cu < ONE_BYTE_LIMIT) begin
            seq[0] = cu[7:0];
            n = 1;
          end else if (cu < TWO_BYTE_LIMIT) begin
            seq[0] = LEAD2 | {3'b0, cu[10:6]};
            seq[1] = CONT | {2'b0, cu[5:0]};
            n = 2;
          end else if (cu >= SURR_HIGH_FIRST && cu <= SURR_HIGH_LAST) begin
            // held for the next unit unless the string ends here
            if (!last) begin
              held_bits  = cu[9:0];
              held_valid = 1'b1;
            end
          end else begin
            seq[0] = LEAD3 | {4'b0, cu[15:12]};
            seq[1] = CONT | {2'b0, cu[11:6]};
            seq[2] = CONT | {2'b0, cu[5:0]};
            n = 3;
          end
        end
      end
    end
    if (last) begin
      held_valid  = 1'b0;
      held_bits   = '0;
      string_done = 1'b0;
    end
    if (n == 0) begin
      r = '{data: 8'h00, has_byte: 1'b0, run_last: 1'b1, string_end: last};
      expected_bytes_q = {expected_bytes_q, r};
    end else begin
      for (int k = 0; k < n; k++) begin
        r = '{data: seq[k], has_byte: 1'b1, run_last: (k == n - 1),
              string_end: (k == n - 1) && last};
        expected_bytes_q = {expected_bytes_q, r};
      end
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    utf8_result_t want;
    if (!rst_ni) begin
      held_bits   = '0;
      held_valid  = 1'b0;
      string_done = 1'b0;
      expected_bytes_q.delete();
      errors  = 0;
      units   = 0;
      results = 0;
      strings = 0;
      error_count_o   <= 0;
      expected_left_o <= 0;
      units_seen_o    <= 0;
      results_seen_o  <= 0;
      strings_seen_o  <= 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        units++;
        encode_utf8_unit(code_unit_i, last_unit_i);
      end
      if (out_valid_i && out_ready_i) begin
        results++;
        if (string_end_i === 1'b1) strings++;
        if (expected_bytes_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected item, expected none, actual byte %h has %b last %b end %b",
                   $time, utf8_byte_i, has_byte_i, run_last_i, string_end_i);
        end else begin
          want = expected_bytes_q.pop_front();
          check_field("utf8_byte", want.data, utf8_byte_i);
          check_field("has_byte", {7'b0, want.has_byte}, {7'b0, has_byte_i});
          check_field("run_last", {7'b0, want.run_last}, {7'b0, run_last_i});
          check_field("string_end", {7'b0, want.string_end}, {7'b0, string_end_i});
        end
      end
      error_count_o   <= errors;
      expected_left_o <= expected_bytes_q.size();
      units_seen_o    <= units;
      results_seen_o  <= results;
      strings_seen_o  <= strings;
    end
  end

endmodule

@@ tb/sv/utf16_to_utf8_converter_tb.sv @@
`timescale 1ns / 1ps
// testbench top for the utf-16 to utf-8 transcoder: clock, reset, stimulus, verdict
// depends on u2u8_pkg, the transcoder rtl and utf8_stream_checker
module utf16_to_utf8_converter_tb;
  import u2u8_pkg::*;

  // generous bound: ~250 items, each up to four items out under long stalls
  localparam int CYCLE_LIMIT  = 400_000;
  localparam int RANDOM_UNITS = 220;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [15:0] code_unit_i;
  logic        last_unit_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [7:0]  utf8_byte_o;
  logic        has_byte_o;
  logic        run_last_o;
  logic        string_end_o;

  int error_count;
  int expected_left;
  int units_seen;
  int results_seen;
  int strings_seen;

  int cycle_count;
  int random_units;
  // when set, neither side idles: back-to-back traffic
  bit calm;

  utf16_to_utf8_converter dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .code_unit_i  (code_unit_i),
    .last_unit_i  (last_unit_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .utf8_byte_o  (utf8_byte_o),
    .has_byte_o   (has_byte_o),
    .run_last_o   (run_last_o),
    .string_end_o (string_end_o)
  );

  // watches both channels, predicts and compares
  utf8_stream_checker stream_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .code_unit_i     (code_unit_i),
    .last_unit_i     (last_unit_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .utf8_byte_i     (utf8_byte_o),
    .has_byte_i      (has_byte_o),
    .run_last_i      (run_last_o),
    .string_end_i    (string_end_o),
    .error_count_o   (error_count),
    .expected_left_o (expected_left),
    .units_seen_o    (units_seen),
    .results_seen_o  (results_seen),
    .strings_seen_o  (strings_seen)
  );

  // 2 ns clock
  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // watchdog: a hung handshake ends the run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d items still expected", cycle_count,
               expected_left);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // output side: runs of ready broken by random stalls
  initial begin
    int n;
    out_ready_i <= 1'b0;
    wait (rst_ni);
    forever begin
      out_ready_i <= 1'b1;
      n = $urandom_range(1, 12);
      repeat (n) @(posedge clk_i);
      n = pick_gap();
      if (n > 0) begin
        out_ready_i <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
    end
  end

  // one code unit on the input channel; valid is only dropped for a real gap,
  // so it never gets two assignments in one step
  task automatic send_unit(input logic [15:0] cu, input logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    code_unit_i <= cu;
    last_unit_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  function automatic logic [15:0] rand_high_surr();
    return 16'($urandom_range(SURR_HIGH_FIRST, SURR_HIGH_LAST));
  endfunction

  function automatic logic [15:0] rand_low_surr();
    return 16'($urandom_range(SURR_LOW_FIRST, SURR_LOW_LAST));
  endfunction

  // a well-formed string with random content, last unit flagged; now and then
  // a lone surrogate or an early terminator followed by junk
  task automatic send_random_string();
    logic [15:0] units[$];
    int          len;
    int          kind;
    bit          after_zero;
    len = $urandom_range(1, 7);
    after_zero = 1'b0;
    for (int k = 0; k < len; k++) begin
      kind = $urandom_range(0, 19);
      if (kind < 5) begin
        units = {units, 16'($urandom_range(1, ONE_BYTE_LIMIT - 1))};
      end else if (kind < 8) begin
        units = {units, 16'($urandom_range(ONE_BYTE_LIMIT, TWO_BYTE_LIMIT - 1))};
      end else if (kind < 11) begin
        // three-byte range on either side of the surrogate block
        if ($urandom_range(0, 1))
          units = {units, 16'($urandom_range(TWO_BYTE_LIMIT, SURR_HIGH_FIRST - 1))};
        else
          units = {units, 16'($urandom_range(SURR_LOW_LAST + 1, 16'hFFFF))};
      end else if (kind < 16) begin
        units = {units, rand_high_surr()};
        units = {units, rand_low_surr()};
      end else if (kind < 17) begin
        units = {units, rand_high_surr()};
      end else if (kind < 18) begin
        units = {units, rand_low_surr()};
      end else if (kind < 19) begin
        units = {units, 16'($urandom_range(1, 16'hFFFF))};
      end else begin
        units = {units, 16'h0000};
      end
    end
    foreach (units[i]) begin
      if (!after_zero) random_units++;
      send_unit(units[i], i == units.size() - 1);
      if (units[i] == 16'h0000) after_zero = 1'b1;
    end
  endtask

  initial begin
    in_valid_i   <= 1'b0;
    code_unit_i  <= 16'h0000;
    last_unit_i  <= 1'b0;
    rst_ni       <= 1'b0;
    random_units = 0;
    calm         = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed: encoding boundaries ---
    send_unit(16'h007F, 1'b0);    // largest one-byte
    send_unit(16'h0080, 1'b0);    // smallest two-byte
    send_unit(16'h07FF, 1'b0);    // largest two-byte
    send_unit(16'h0800, 1'b1);    // smallest three-byte, ends a string
    send_unit(16'hD7FF, 1'b0);    // just below the surrogate block
    send_unit(16'hE000, 1'b0);    // just above it
    send_unit(16'hFFFF, 1'b0);    // all ones
    // surrogate pairs at both extremes
    send_unit(16'hD800, 1'b0);
    send_unit(16'hDC00, 1'b0);
    send_unit(16'hDBFF, 1'b0);
    send_unit(16'hDFFF, 1'b1);    // pair closes the string
    // lone low surrogate goes out as three bytes
    send_unit(16'hDC00, 1'b0);
    // held high dropped by a plain unit, which is then encoded
    send_unit(16'hD834, 1'b0);
    send_unit(16'h0041, 1'b0);
    // held high replaced by another high, which then pairs
    send_unit(16'hD800, 1'b0);
    send_unit(16'hD801, 1'b0);
    send_unit(16'hDC01, 1'b0);
    // high surrogate as the last unit is dropped
    send_unit(16'hDABC, 1'b1);
    // terminator mid-string, then ignored units up to the flagged one
    send_unit(16'h0000, 1'b0);
    send_unit(16'h1234, 1'b0);
    send_unit(16'hD800, 1'b0);
    send_unit(16'hFFFF, 1'b1);
    // terminator flagged last, and a held high dropped by a terminator
    send_unit(16'h0000, 1'b1);
    send_unit(16'hD900, 1'b0);
    send_unit(16'h0000, 1'b1);

    // --- random: mostly well-formed strings, some raw noise ---
    while (random_units < RANDOM_UNITS) begin
      calm = ((random_units / 30) % 4 == 3);
      if ($urandom_range(0, 9) == 0) begin
        random_units++;
        send_unit(16'($urandom()), 1'($urandom_range(0, 1)));
      end else begin
        send_random_string();
      end
    end
    calm = 1'b0;
    in_valid_i <= 1'b0;

    // drain: wait for the registered checker count, then allow for stray output
    @(posedge clk_i);
    wait (expected_left == 0);
    repeat (8) @(posedge clk_i);

    $display("run covered %0d code units in %0d closed strings, %0d items checked",
             units_seen, strings_seen, results_seen);
    $display("boundary values, surrogate pairs, lone and dropped surrogates, terminators");
    if (error_count == 0 && expected_left == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+src
src/u2u8_pkg.sv
src/u2u8_front.sv
src/u2u8_queue.sv
src/u2u8_back.sv
src/utf16_to_utf8_converter.sv
tb/sv/utf8_stream_checker.sv
tb/sv/utf16_to_utf8_converter_tb.sv
